// ----- hdl/sha256_hash_engine_macros.svh -----
// Assertion helpers for the hash engine checker
`ifndef SHA256_HASH_ENGINE_MACROS_SVH
`define SHA256_HASH_ENGINE_MACROS_SVH
// Implication checked on every clock, held off during reset
`define SHA_ASSERT_IMPL(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) else $error(msg);
// Implication with the consequent checked in the next cycle
`define SHA_ASSERT_NEXT(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) else $error(msg);
`endif

// ----- hdl/sha256_pkg.sv -----
package sha256_pkg;

  localparam int LengthWidthDef = 64;

  typedef struct packed {
    logic [7:0] data;
    logic       has_data;
    logic       end_of_message;
  } in_req_t;

  typedef struct packed {
    logic [31:0] digest_word;
    logic [2:0]  word_index;
    logic        last;
  } out_req_t;

  typedef enum logic [2:0] {
    ST_IDLE,
    ST_PAD,
    ST_SCHED,
    ST_ROUND,
    ST_FOLD,
    ST_EMIT
  } state_t;

  // Control from sequencer to the round datapath
  typedef struct packed {
    logic       init_vars;
    logic       round_en;
    logic [5:0] round;
  } rnd_ctl_t;

  function automatic logic [31:0] round_k(input logic [5:0] i);
    logic [31:0] k [64];
    k = '{32'h428a2f98,32'h71374491,32'hb5c0fbcf,32'he9b5dba5,32'h3956c25b,32'h59f111f1,
          32'h923f82a4,32'hab1c5ed5,32'hd807aa98,32'h12835b01,32'h243185be,32'h550c7dc3,
          32'h72be5d74,32'h80deb1fe,32'h9bdc06a7,32'hc19bf174,32'he49b69c1,32'hefbe4786,
          32'h0fc19dc6,32'h240ca1cc,32'h2de92c6f,32'h4a7484aa,32'h5cb0a9dc,32'h76f988da,
          32'h983e5152,32'ha831c66d,32'hb00327c8,32'hbf597fc7,32'hc6e00bf3,32'hd5a79147,
          32'h06ca6351,32'h14292967,32'h27b70a85,32'h2e1b2138,32'h4d2c6dfc,32'h53380d13,
          32'h650a7354,32'h766a0abb,32'h81c2c92e,32'h92722c85,32'ha2bfe8a1,32'ha81a664b,
          32'hc24b8b70,32'hc76c51a3,32'hd192e819,32'hd6990624,32'hf40e3585,32'h106aa070,
          32'h19a4c116,32'h1e376c08,32'h2748774c,32'h34b0bcb5,32'h391c0cb3,32'h4ed8aa4a,
          32'h5b9cca4f,32'h682e6ff3,32'h748f82ee,32'h78a5636f,32'h84c87814,32'h8cc70208,
          32'h90befffa,32'ha4506ceb,32'hbef9a3f7,32'hc67178f2};
    return k[i];
  endfunction

  function automatic logic [31:0] init_hash(input logic [2:0] i);
    logic [31:0] h [8];
    h = '{32'h6a09e667,32'hbb67ae85,32'h3c6ef372,32'ha54ff53a,
          32'h510e527f,32'h9b05688c,32'h1f83d9ab,32'h5be0cd19};
    return h[i];
  endfunction

  function automatic logic [31:0] ror(input logic [31:0] v, input int s);
    return (v >> s) | (v << (32 - s));
  endfunction

endpackage

// ----- hdl/sha256_hash_engine.sv -----
// Channel | Ports                          | Request accepted when
// input   | in_valid in_stall in_data      | in_valid && !in_stall
// output  | out_valid out_stall out_data   | out_valid && !out_stall
// A byte that fills a block starts the steps below, with the input stalled.
// Each block: load the schedule memory into the window, run the rounds with
// the 48 expansion writes overlapped, then fold the chain.
// End of message: padding one byte per cycle, one or two blocks, 8 outputs.
// Reset (rst_n low, synchronous) restarts the message; no clearing pass, the
// message memory is written before each read. out_stall holds a word in place.
module sha256_hash_engine #(
  parameter int LENGTH_WIDTH = sha256_pkg::LengthWidthDef
) (
  input  logic                clk,
  input  logic                rst_n,
  input  logic                in_valid,
  output logic                in_stall,
  input  sha256_pkg::in_req_t in_data,
  output logic                out_valid,
  input  logic                out_stall,
  output sha256_pkg::out_req_t out_data
);

  sha256_pkg::state_t state_r, state_nxt;

  // message schedule memory: 64 words, w[0..15] from bytes, rest expanded
  logic [31:0] wmem [64];
  logic [31:0] wrd_r;
  logic [5:0]  rd_addr;
  logic        wr_en;
  logic [5:0]  wr_addr;
  logic [31:0] wr_data;

  logic [31:0] win_r [16];
  logic [31:0] hash_r [8];
  logic [5:0]  bcnt_r, bcnt_nxt;
  logic [LENGTH_WIDTH-1:0] len_r, len_nxt;
  logic [6:0]  cnt_r, cnt_nxt;
  logic [2:0]  pad_ph_r, pad_ph_nxt; // 0: 0x80, 1: zeros, 2: length bytes
  logic        pad_r, pad_nxt;
  logic [3:0]  lb_r, lb_nxt;
  logic [31:0] cur_word_r;
  logic [63:0] len64;
  logic [7:0]  byte_in;
  logic        byte_go;
  logic [255:0] vars, chain;
  sha256_pkg::rnd_ctl_t ctl;
  logic [31:0] s0, s1, wexp;
  logic        exp_go;

  assign len64 = 64'(len_r);
  assign in_stall = (state_r != sha256_pkg::ST_IDLE);

  // byte source: input or padding
  always_comb begin
    byte_go = 1'b0;
    byte_in = in_data.data;
    if (state_r == sha256_pkg::ST_IDLE) begin
      byte_go = in_valid && in_data.has_data;
    end else if (state_r == sha256_pkg::ST_PAD) begin
      byte_go = 1'b1;
      if (pad_ph_r == 3'd0) byte_in = 8'h80;
      else if (pad_ph_r == 3'd1) byte_in = 8'h00;
      else byte_in = len64[8*(7-lb_r[2:0]) +: 8];
    end
  end

  // expansion from the window
  always_comb begin
    s0 = sha256_pkg::ror(win_r[1], 7) ^ sha256_pkg::ror(win_r[1], 18) ^ (win_r[1] >> 3);
    s1 = sha256_pkg::ror(win_r[14], 17) ^ sha256_pkg::ror(win_r[14], 19) ^ (win_r[14] >> 10);
    wexp = win_r[0] + s0 + win_r[9] + s1;
  end

  // memory write port: packed bytes or expanded words
  always_comb begin
    wr_en = 1'b0;
    wr_addr = {2'b00, bcnt_r[5:2]};
    wr_data = {cur_word_r[23:0], byte_in};
    exp_go = 1'b0;
    if (byte_go && bcnt_r[1:0] == 2'd3) wr_en = 1'b1;
    if (state_r == sha256_pkg::ST_ROUND && cnt_r < 7'd48) begin
      exp_go = 1'b1;
      wr_en = 1'b1;
      wr_addr = 6'(cnt_r + 7'd16);
      wr_data = wexp;
    end
  end

  assign rd_addr = cnt_r[5:0];

  always_ff @(posedge clk) begin
    if (wr_en) wmem[wr_addr] <= wr_data;
    wrd_r <= wmem[rd_addr];
  end

  // byte packing register and window shift
  always_ff @(posedge clk) begin
    if (byte_go) cur_word_r <= {cur_word_r[23:0], byte_in};
    if ((state_r == sha256_pkg::ST_SCHED && cnt_r != 7'd0) || exp_go) begin
      for (int i = 0; i < 15; i++) win_r[i] <= win_r[i+1];
      win_r[15] <= exp_go ? wexp : wrd_r;
    end
  end

  always_comb begin
    for (int i = 0; i < 8; i++) chain[255-32*i -: 32] = hash_r[i];
  end

  always_comb begin
    ctl.init_vars = (state_r == sha256_pkg::ST_SCHED && cnt_r == 7'd0);
    ctl.round_en  = (state_r == sha256_pkg::ST_ROUND && cnt_r != 7'd0);
    ctl.round     = 6'(cnt_r - 7'd1);
  end

  // round input: every word comes from the memory read register
  sha256_rounds u_rounds (
    .clk  (clk),
    .ctl  (ctl),
    .chain(chain),
    .w_in (wrd_r),
    .vars (vars)
  );

  // sequencer
  always_comb begin
    state_nxt  = state_r;
    bcnt_nxt   = bcnt_r;
    len_nxt    = len_r;
    cnt_nxt    = cnt_r;
    pad_ph_nxt = pad_ph_r;
    pad_nxt    = pad_r;
    lb_nxt     = lb_r;
    if (byte_go) bcnt_nxt = bcnt_r + 6'd1;
    unique case (state_r)
      sha256_pkg::ST_IDLE: begin
        if (in_valid) begin
          if (in_data.has_data) len_nxt = len_r + LENGTH_WIDTH'(8);
          pad_nxt = in_data.end_of_message;
          pad_ph_nxt = 3'd0;
          lb_nxt = 4'd0;
          if (in_data.has_data && bcnt_r == 6'd63) begin
            state_nxt = sha256_pkg::ST_SCHED; cnt_nxt = 7'd0;
          end else if (in_data.end_of_message) begin
            state_nxt = sha256_pkg::ST_PAD;
          end
        end
      end
      sha256_pkg::ST_PAD: begin
        if (pad_ph_r == 3'd0) pad_ph_nxt = (bcnt_r == 6'd55) ? 3'd2 : 3'd1;
        else if (pad_ph_r == 3'd1) begin
          if (bcnt_r == 6'd55) pad_ph_nxt = 3'd2;
        end else begin
          lb_nxt = lb_r + 4'd1;
          if (lb_r == 4'd7) pad_nxt = 1'b0;
        end
        if (bcnt_r == 6'd63) begin
          state_nxt = sha256_pkg::ST_SCHED; cnt_nxt = 7'd0;
        end
      end
      sha256_pkg::ST_SCHED: begin
        // read w[0..15] into the window through the read register
        cnt_nxt = cnt_r + 7'd1;
        if (cnt_r == 7'd16) begin
          state_nxt = sha256_pkg::ST_ROUND; cnt_nxt = 7'd0;
        end
      end
      sha256_pkg::ST_ROUND: begin
        cnt_nxt = cnt_r + 7'd1;
        if (cnt_r == 7'd64) begin
          state_nxt = sha256_pkg::ST_FOLD; cnt_nxt = 7'd0;
        end
      end
      sha256_pkg::ST_FOLD: begin
        if (pad_r) state_nxt = sha256_pkg::ST_PAD;
        else if (pad_ph_r == 3'd2) begin state_nxt = sha256_pkg::ST_EMIT; cnt_nxt = 7'd0; end
        else state_nxt = sha256_pkg::ST_IDLE;
      end
      sha256_pkg::ST_EMIT: begin
        if (!out_stall) begin
          cnt_nxt = cnt_r + 7'd1;
          if (cnt_r == 7'd7) begin
            state_nxt = sha256_pkg::ST_IDLE; cnt_nxt = 7'd0;
            len_nxt = '0; pad_ph_nxt = 3'd0;
          end
        end
      end
      default: state_nxt = sha256_pkg::ST_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r  <= sha256_pkg::ST_IDLE;
      bcnt_r   <= '0;
      len_r    <= '0;
      cnt_r    <= '0;
      pad_ph_r <= '0;
      pad_r    <= 1'b0;
      lb_r     <= '0;
    end else begin
      state_r  <= state_nxt;
      bcnt_r   <= bcnt_nxt;
      len_r    <= len_nxt;
      cnt_r    <= cnt_nxt;
      pad_ph_r <= pad_ph_nxt;
      pad_r    <= pad_nxt;
      lb_r     <= lb_nxt;
    end
  end

  // chain hash: fold after a block, restore after the digest leaves
  always_ff @(posedge clk) begin
    if (!rst_n || (state_r == sha256_pkg::ST_EMIT && !out_stall && cnt_r == 7'd7)) begin
      for (int i = 0; i < 8; i++) hash_r[i] <= sha256_pkg::init_hash(3'(i));
    end else if (state_r == sha256_pkg::ST_FOLD) begin
      for (int i = 0; i < 8; i++) hash_r[i] <= hash_r[i] + vars[255-32*i -: 32];
    end
  end

  assign out_valid = (state_r == sha256_pkg::ST_EMIT);
  assign out_data.digest_word = hash_r[cnt_r[2:0]];
  assign out_data.word_index  = cnt_r[2:0];
  assign out_data.last        = (cnt_r[2:0] == 3'd7);

endmodule

// ----- hdl/sha256_rounds.sv -----
// Round datapath: eight working variables updated once per cycle while round_en is set
module sha256_rounds (
  input  logic                clk,
  input  sha256_pkg::rnd_ctl_t ctl,
  input  logic [255:0]        chain,
  input  logic [31:0]         w_in,
  output logic [255:0]        vars
);

  logic [31:0] v_r [8];
  logic [31:0] e1, ch, t1, a0, mj, t2;

  always_comb begin
    e1 = sha256_pkg::ror(v_r[4], 6) ^ sha256_pkg::ror(v_r[4], 11) ^ sha256_pkg::ror(v_r[4], 25);
    ch = (v_r[4] & v_r[5]) ^ (~v_r[4] & v_r[6]);
    t1 = v_r[7] + e1 + ch + sha256_pkg::round_k(ctl.round) + w_in;
    a0 = sha256_pkg::ror(v_r[0], 2) ^ sha256_pkg::ror(v_r[0], 13) ^ sha256_pkg::ror(v_r[0], 22);
    mj = (v_r[0] & v_r[1]) ^ (v_r[0] & v_r[2]) ^ (v_r[1] & v_r[2]);
    t2 = a0 + mj;
  end

  // Load from the chain or advance one round
  always_ff @(posedge clk) begin
    if (ctl.init_vars) begin
      for (int i = 0; i < 8; i++) v_r[i] <= chain[255-32*i -: 32];
    end else if (ctl.round_en) begin
      v_r[7] <= v_r[6]; v_r[6] <= v_r[5]; v_r[5] <= v_r[4]; v_r[4] <= v_r[3] + t1;
      v_r[3] <= v_r[2]; v_r[2] <= v_r[1]; v_r[1] <= v_r[0]; v_r[0] <= t1 + t2;
    end
  end

  always_comb begin
    for (int i = 0; i < 8; i++) vars[255-32*i -: 32] = v_r[i];
  end

endmodule

// ----- hdl/sha256_checker.sv -----
`include "sha256_hash_engine_macros.svh"
// Port-level checks of the hash engine
module sha256_checker (
  input logic                 clk,
  input logic                 rst_n,
  input logic                 in_valid,
  input logic                 in_stall,
  input sha256_pkg::out_req_t out_data,
  input logic                 out_valid,
  input logic                 out_stall
);
  `SHA_ASSERT_IMPL(a_no_overlap, out_valid && in_valid, in_stall, "input taken during digest output")
  `SHA_ASSERT_NEXT(a_hold, out_valid && out_stall, out_valid && $stable(out_data), "stalled word moved")
  `SHA_ASSERT_NEXT(a_order, out_valid && !out_stall && !out_data.last,
    out_valid && out_data.word_index == $past(out_data.word_index) + 3'd1, "digest word skipped")
  `SHA_ASSERT_IMPL(a_last, out_valid, out_data.last == (out_data.word_index == 3'd7), "last flag wrong")
endmodule

bind sha256_hash_engine sha256_checker u_chk (
  .clk(clk), .rst_n(rst_n), .in_valid(in_valid), .in_stall(in_stall),
  .out_data(out_data), .out_valid(out_valid), .out_stall(out_stall)
);
